// ===== hdl/llpq_pkg.sv =====
package llpq_pkg;

  localparam int NUM_QUEUES_DEF  = 4;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int LOAD_W          = 16;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    REQ_ARRIVE = 1'b0,
    REQ_REMOVE = 1'b1
  } req_e;

  typedef struct packed {
    logic [7:0]  work;
    logic [6:0]  prio;
    logic [15:0] id;
  } entry_t;

  typedef struct packed {
    logic pop;
    logic ins;
    logic tail_lt;
    logic occ;
    logic at_fill;
    logic left_le;
  } cell_ctrl_t;

endpackage

// ===== hdl/llpq_cell.sv =====
module llpq_cell (
  input  logic                clk_i,
  input  llpq_pkg::entry_t    new_i,
  input  llpq_pkg::entry_t    left_i,
  input  llpq_pkg::entry_t    right_i,
  input  llpq_pkg::cell_ctrl_t ctrl_i,
  output llpq_pkg::entry_t    entry_o,
  output logic                le_o,
  output logic                lt_o
);
  import llpq_pkg::*;

  entry_t entry_q, entry_d;

  assign le_o    = ctrl_i.occ & (entry_q.prio <= new_i.prio);
  assign lt_o    = ctrl_i.occ & (entry_q.prio <  new_i.prio);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    priority if (ctrl_i.pop) begin
      entry_d = right_i;
    end else if (ctrl_i.ins) begin
      if (ctrl_i.tail_lt) begin
        if (ctrl_i.left_le) begin
          entry_d = left_i;
        end else if (le_o) begin
          entry_d = new_i;
        end
      end else if (ctrl_i.at_fill) begin
        entry_d = new_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== hdl/llpq_row.sv =====
module llpq_row #(
  parameter int QUEUE_DEPTH = llpq_pkg::QUEUE_DEPTH_DEF,
  parameter int FILL_W      = $clog2(QUEUE_DEPTH + 1),
  parameter int POS_W       = $clog2(QUEUE_DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        ins_i,
  input  logic                        pop_i,
  input  llpq_pkg::entry_t            new_i,
  output logic [FILL_W-1:0]           fill_o,
  output logic                        full_o,
  output logic [llpq_pkg::LOAD_W-1:0] load_o,
  output logic [llpq_pkg::LOAD_W-1:0] load_sum_o,
  output logic [POS_W-1:0]            pos_o,
  output llpq_pkg::entry_t            head_o
);
  import llpq_pkg::*;

  logic [FILL_W-1:0] fill_q, fill_d;
  logic [LOAD_W-1:0] load_q, load_d;
  logic [LOAD_W:0]   sum;
  entry_t            ent [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] le, lt, hot;
  logic              tail_lt, ins, pop;
  logic [POS_W-1:0]  hot_pos;

  assign full_o  = (fill_q == FILL_W'(QUEUE_DEPTH));
  assign ins     = ins_i & ~full_o;
  assign pop     = pop_i & (fill_q != '0);
  assign tail_lt = |lt;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cell_ctrl_t ctrl;
    entry_t     left, right;
    if (i == 0) begin : g_first
      assign left          = new_i;
      assign ctrl.left_le  = 1'b0;
      assign hot[i]        = le[i];
    end else begin : g_mid
      assign left          = ent[i-1];
      assign ctrl.left_le  = le[i-1];
      assign hot[i]        = le[i] & ~le[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right = ent[i];
    end else begin : g_inner
      assign right = ent[i+1];
    end
    assign ctrl.pop     = pop;
    assign ctrl.ins     = ins;
    assign ctrl.tail_lt = tail_lt;
    assign ctrl.occ     = (FILL_W'(i) < fill_q);
    assign ctrl.at_fill = (FILL_W'(i) == fill_q);

    llpq_cell u_cell (
      .clk_i   (clk_i),
      .new_i   (new_i),
      .left_i  (left),
      .right_i (right),
      .ctrl_i  (ctrl),
      .entry_o (ent[i]),
      .le_o    (le[i]),
      .lt_o    (lt[i])
    );
  end

  always_comb begin
    hot_pos = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (hot[i]) begin
        hot_pos = hot_pos | POS_W'(i);
      end
    end
  end

  assign pos_o      = tail_lt ? hot_pos : fill_q[POS_W-1:0];
  assign sum        = {1'b0, load_q} + (LOAD_W + 1)'(new_i.work);
  assign load_sum_o = sum[LOAD_W] ? '1 : sum[LOAD_W-1:0];
  assign fill_o     = fill_q;
  assign load_o     = load_q;
  assign head_o     = ent[0];

  always_comb begin
    fill_d = fill_q;
    load_d = load_q;
    priority if (ins) begin
      fill_d = fill_q + FILL_W'(1);
      load_d = load_sum_o;
    end else if (pop) begin
      fill_d = fill_q - FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      load_q <= '0;
    end else begin
      fill_q <= fill_d;
      load_q <= load_d;
    end
  end

endmodule

// ===== hdl/least_loaded_priority_queue_dispatch_top.sv =====
// channel  signals                                   direction
// in       in_valid_i / in_stall_o, request fields   into block
// out      out_valid_o / out_stall_i, result fields  out of block
//
// each request resolves in its transfer cycle; the result sits in an output
// register the cycle after, so one request per cycle is taken unless stalled
// queues are rows of slot cells; pop shifts all, insert later ones, at once
// reset clears fills, loads and the output valid; slot contents are not reset
// the input stalls only while a result is held and the output is stalled
module least_loaded_priority_queue_dispatch_top #(
  parameter int NUM_QUEUES  = llpq_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = llpq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [7:0]  job_work_i,
  input  logic [6:0]  job_priority_i,
  input  logic [15:0] job_id_i,
  input  logic [1:0]  target_queue_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [1:0]  chosen_queue_o,
  output logic [3:0]  insert_position_o,
  output logic [4:0]  queue_fill_o,
  output logic [15:0] queue_load_o,
  output logic [7:0]  out_work_o,
  output logic [6:0]  out_priority_o,
  output logic [15:0] out_id_o
);
  import llpq_pkg::*;

  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int POS_W  = $clog2(QUEUE_DEPTH);
  localparam int QIDX_W = $clog2(NUM_QUEUES);

  logic [FILL_W-1:0] fill     [NUM_QUEUES];
  logic [LOAD_W-1:0] load     [NUM_QUEUES];
  logic [LOAD_W-1:0] load_sum [NUM_QUEUES];
  logic [POS_W-1:0]  pos      [NUM_QUEUES];
  entry_t            head     [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] full;

  entry_t            new_ent;
  logic              xfer, arrive;
  logic [QIDX_W-1:0] pick, empty_pick, min_pick, tgt_idx;
  logic              found_empty, tgt_ok;

  logic        out_valid_q;
  logic [1:0]  status_q, status_d;
  logic [1:0]  queue_q, queue_d;
  logic [3:0]  ipos_q, ipos_d;
  logic [4:0]  fill_q, fill_d;
  logic [15:0] load_q, load_d;
  entry_t      oent_q, oent_d;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign xfer       = in_valid_i & ~in_stall_o;
  assign arrive     = (req_type_i == REQ_ARRIVE);
  assign new_ent    = '{work: job_work_i, prio: job_priority_i, id: job_id_i};
  assign tgt_ok     = (int'(target_queue_i) < NUM_QUEUES);
  assign tgt_idx    = tgt_ok ? QIDX_W'(target_queue_i) : '0;

  always_comb begin
    empty_pick  = '0;
    found_empty = 1'b0;
    for (int q = 0; q < NUM_QUEUES; q++) begin
      if (!found_empty && fill[q] == '0) begin
        empty_pick  = QIDX_W'(q);
        found_empty = 1'b1;
      end
    end
    min_pick = '0;
    for (int q = 1; q < NUM_QUEUES; q++) begin
      if (load[q] < load[min_pick]) begin
        min_pick = QIDX_W'(q);
      end
    end
    pick = found_empty ? empty_pick : min_pick;
  end

  for (genvar q = 0; q < NUM_QUEUES; q++) begin : g_row
    llpq_row #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .FILL_W      (FILL_W),
      .POS_W       (POS_W)
    ) u_row (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ins_i      (xfer & arrive & (pick == QIDX_W'(q))),
      .pop_i      (xfer & ~arrive & tgt_ok & (tgt_idx == QIDX_W'(q))),
      .new_i      (new_ent),
      .fill_o     (fill[q]),
      .full_o     (full[q]),
      .load_o     (load[q]),
      .load_sum_o (load_sum[q]),
      .pos_o      (pos[q]),
      .head_o     (head[q])
    );
  end

  always_comb begin
    status_d = STATUS_OK;
    queue_d  = 2'(pick);
    ipos_d   = '0;
    fill_d   = '0;
    load_d   = '0;
    oent_d   = '0;
    if (arrive) begin
      if (full[pick]) begin
        status_d = STATUS_FULL;
        fill_d   = 5'(fill[pick]);
        load_d   = load[pick];
      end else begin
        ipos_d   = 4'(pos[pick]);
        fill_d   = 5'(fill[pick] + FILL_W'(1));
        load_d   = load_sum[pick];
      end
    end else begin
      queue_d = target_queue_i;
      if (!tgt_ok) begin
        status_d = STATUS_EMPTY;
      end else if (fill[tgt_idx] == '0) begin
        status_d = STATUS_EMPTY;
        load_d   = load[tgt_idx];
      end else begin
        fill_d   = 5'(fill[tgt_idx] - FILL_W'(1));
        load_d   = load[tgt_idx];
        oent_d   = head[tgt_idx];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (xfer) begin
      status_q <= status_d;
      queue_q  <= queue_d;
      ipos_q   <= ipos_d;
      fill_q   <= fill_d;
      load_q   <= load_d;
      oent_q   <= oent_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign chosen_queue_o    = queue_q;
  assign insert_position_o = ipos_q;
  assign queue_fill_o      = fill_q;
  assign queue_load_o      = load_q;
  assign out_work_o        = oent_q.work;
  assign out_priority_o    = oent_q.prio;
  assign out_id_o          = oent_q.id;

endmodule

// ===== hdl/llpq_checker.sv =====
module llpq_checker #(
  parameter int QUEUE_DEPTH = llpq_pkg::QUEUE_DEPTH_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [3:0]  insert_position_o,
  input logic [4:0]  queue_fill_o,
  input logic [7:0]  out_work_o,
  input logic [6:0]  out_priority_o,
  input logic [15:0] out_id_o
);
  import llpq_pkg::*;

  // stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // every input transfer yields a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("input transfer without result");

  // failed requests carry no entry and no position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STATUS_OK |->
      out_work_o == '0 && out_priority_o == '0 && out_id_o == '0 &&
      insert_position_o == '0)
    else $error("failed request carries payload");

  // rejection only from a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_FULL |-> queue_fill_o == 5'(QUEUE_DEPTH))
    else $error("rejection from queue that is not full");

endmodule

bind least_loaded_priority_queue_dispatch_top llpq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_llpq_checker (.*);

// ===== bench/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import llpq_pkg::*;

  localparam int NQ    = NUM_QUEUES_DEF;
  localparam int DEPTH = QUEUE_DEPTH_DEF;
  localparam int NUM_ITEMS = 1450;

  typedef struct packed {
    req_e        kind;
    logic [7:0]  work;
    logic [6:0]  prio;
    logic [15:0] id;
    logic [1:0]  target;
  } request_t;

  typedef struct packed {
    status_e     status;
    logic [1:0]  queue_sel;
    logic [3:0]  pos;
    logic [4:0]  fill;
    logic [15:0] load;
    logic [7:0]  work;
    logic [6:0]  prio;
    logic [15:0] id;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  request_t    drv_req = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        hold_off = 1'b0;
  logic [1:0]  status;
  logic [1:0]  chosen_queue;
  logic [3:0]  insert_position;
  logic [4:0]  queue_fill;
  logic [15:0] queue_load;
  logic [7:0]  out_work;
  logic [6:0]  out_priority;
  logic [15:0] out_id;

  request_t pending_reqs[$];
  outcome_t expected_outcomes[$];

  entry_t      model_slots [NQ][DEPTH];
  int          model_fill  [NQ];
  logic [15:0] model_load  [NQ];

  int accepted_cnt = 0;
  int result_cnt = 0;
  int mismatch_cnt = 0;
  int send_wait = 0;
  int stall_wait = 0;

  always #5 clk_i = ~clk_i;

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  least_loaded_priority_queue_dispatch_top #(
    .NUM_QUEUES (NQ),
    .QUEUE_DEPTH(DEPTH)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .req_type_i       (drv_req.kind),
    .job_work_i       (drv_req.work),
    .job_priority_i   (drv_req.prio),
    .job_id_i         (drv_req.id),
    .target_queue_i   (drv_req.target),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .status_o         (status),
    .chosen_queue_o   (chosen_queue),
    .insert_position_o(insert_position),
    .queue_fill_o     (queue_fill),
    .queue_load_o     (queue_load),
    .out_work_o       (out_work),
    .out_priority_o   (out_priority),
    .out_id_o         (out_id)
  );

  // idle profile changes every 150 transfers: none, sender, receiver, both
  function automatic int idle_limit(int n, bit receiver);
    int seg;
    seg = (n / 150) % 4;
    return (receiver ? seg[1] : seg[0]) ? 8 : 0;
  endfunction

  function automatic outcome_t predict_dispatch(request_t r);
    outcome_t o;
    int q, i, fill, pos;
    int unsigned sum;
    o = '0;
    o.status = STATUS_OK;
    if (r.kind == REQ_ARRIVE) begin
      q = -1;
      for (i = 0; i < NQ; i++) begin
        if (q < 0 && model_fill[i] == 0) q = i;
      end
      if (q < 0) begin
        q = 0;
        for (i = 1; i < NQ; i++) begin
          if (model_load[i] < model_load[q]) q = i;
        end
      end
      fill = model_fill[q];
      o.queue_sel = q[1:0];
      if (fill >= DEPTH) begin
        o.status = STATUS_FULL;
        o.fill = 5'(fill);
        o.load = model_load[q];
      end else begin
        if (fill == 0 || model_slots[q][fill-1].prio >= r.prio) begin
          pos = fill;
        end else begin
          pos = 0;
          while (pos < fill && model_slots[q][pos].prio > r.prio) pos++;
        end
        for (i = fill; i > pos; i--) model_slots[q][i] = model_slots[q][i-1];
        model_slots[q][pos] = '{work: r.work, prio: r.prio, id: r.id};
        model_fill[q] = fill + 1;
        sum = model_load[q] + r.work;
        if (sum > 32'hffff) sum = 32'hffff;
        model_load[q] = sum[15:0];
        o.pos = 4'(pos);
        o.fill = 5'(fill + 1);
        o.load = model_load[q];
      end
    end else begin
      q = r.target;
      o.queue_sel = r.target;
      if (q >= NQ) begin
        o.status = STATUS_EMPTY;
      end else if (model_fill[q] == 0) begin
        o.status = STATUS_EMPTY;
        o.load = model_load[q];
      end else begin
        o.work = model_slots[q][0].work;
        o.prio = model_slots[q][0].prio;
        o.id = model_slots[q][0].id;
        for (i = 1; i < model_fill[q]; i++) model_slots[q][i-1] = model_slots[q][i];
        model_fill[q]--;
        o.fill = 5'(model_fill[q]);
        o.load = model_load[q];
      end
    end
    return o;
  endfunction

  task automatic flag(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) flag($sformatf("%s expected %0h got %0h", name, want, got));
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    logic take_next;
    logic next_valid;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      send_wait = 0;
      for (int i = 0; i < NQ; i++) begin
        model_fill[i] = 0;
        model_load[i] = '0;
      end
    end else begin
      take_next = !in_valid;
      next_valid = in_valid;
      if (in_valid && !in_stall) begin
        expected_outcomes.push_back(predict_dispatch(drv_req));
        accepted_cnt++;
        send_wait = $urandom_range(0, idle_limit(accepted_cnt, 1'b0));
        take_next = 1'b1;
      end
      if (take_next) begin
        next_valid = 1'b0;
        if (send_wait > 0) begin
          send_wait--;
        end else if (pending_reqs.size() > 0) begin
          drv_req <= pending_reqs.pop_front();
          next_valid = 1'b1;
        end
      end
      in_valid <= next_valid;
    end
  end

  // monitor and receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    logic stall_next;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        result_cnt++;
        if (expected_outcomes.size() == 0) begin
          flag("result transfer with no expectation pending");
        end else begin
          want = expected_outcomes.pop_front();
          check_field("status", want.status, status);
          check_field("chosen_queue", want.queue_sel, chosen_queue);
          check_field("insert_position", want.pos, insert_position);
          check_field("queue_fill", want.fill, queue_fill);
          check_field("queue_load", want.load, queue_load);
          check_field("out_work", want.work, out_work);
          check_field("out_priority", want.prio, out_priority);
          check_field("out_id", want.id, out_id);
        end
        stall_wait = $urandom_range(0, idle_limit(result_cnt, 1'b1));
      end
      stall_next = (stall_wait > 0);
      if (stall_wait > 0) stall_wait--;
      out_stall <= hold_off || stall_next;
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    wait (accepted_cnt >= 700);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (200) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAIL least_loaded_priority_queue_dispatch_top");
    $finish;
  end

  task automatic add_arrival(logic [7:0] work, logic [6:0] prio, logic [15:0] id);
    request_t r;
    r.kind = REQ_ARRIVE;
    r.work = work;
    r.prio = prio;
    r.id = id;
    r.target = 2'($urandom_range(0, 3));
    pending_reqs.push_back(r);
  endtask

  task automatic add_removal(logic [1:0] target);
    request_t r;
    r.kind = REQ_REMOVE;
    r.work = 8'($urandom_range(1, 255));
    r.prio = 7'($urandom_range(1, 127));
    r.id = 16'($urandom_range(0, 65535));
    r.target = target;
    pending_reqs.push_back(r);
  endtask

  task automatic add_random_arrival();
    logic [6:0] prio;
    prio = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(1, 127))
                                       : 7'($urandom_range(1, 6));
    add_arrival(8'($urandom_range(1, 255)), prio, 16'($urandom_range(0, 65535)));
  endtask

  initial begin
    // removal from every empty queue
    for (int q = 0; q < NQ; q++) add_removal(2'(q));
    // empty queues taken in index order, field extremes
    add_arrival(8'd255, 7'd127, 16'hffff);
    add_arrival(8'd1, 7'd1, 16'h0000);
    add_arrival(8'd128, 7'd64, 16'h5555);
    add_arrival(8'd2, 7'd10, 16'haaaa);
    // least load with ties, tail append and sorted insert
    add_arrival(8'd1, 7'd1, 16'h0101);
    add_arrival(8'd5, 7'd100, 16'h0202);
    add_arrival(8'd10, 7'd50, 16'h0303);
    add_arrival(8'd3, 7'd1, 16'h0404);
    add_arrival(8'd1, 7'd50, 16'h0505);
    add_removal(2'd1);
    add_removal(2'd2);
    add_arrival(8'd7, 7'd3, 16'h0606);
    add_removal(2'd0);
    add_removal(2'd0);
    add_removal(2'd3);
    add_removal(2'd3);
    add_removal(2'd3);

    // saturate the load of queue 0 by keeping it the first empty queue
    repeat (DEPTH) add_removal(2'd0);
    repeat (280) begin
      add_arrival(8'($urandom_range(240, 255)), 7'($urandom_range(1, 127)),
                  16'($urandom_range(0, 65535)));
      add_removal(2'd0);
    end

    while (pending_reqs.size() < NUM_ITEMS) begin
      case ($urandom_range(0, 3))
        0: repeat ($urandom_range(20, 80)) add_random_arrival();
        1: repeat ($urandom_range(10, 40)) add_removal(2'($urandom_range(0, 3)));
        default: begin
          repeat ($urandom_range(20, 60)) begin
            if ($urandom_range(0, 1) == 0) add_random_arrival();
            else add_removal(2'($urandom_range(0, 3)));
          end
        end
      endcase
    end

    wait (rst_ni);
    wait (pending_reqs.size() == 0 && !in_valid);
    wait (expected_outcomes.size() == 0);
    repeat (4) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_outcomes.size() == 0) begin
      $display("PASS least_loaded_priority_queue_dispatch_top");
    end else begin
      $display("FAIL least_loaded_priority_queue_dispatch_top");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/llpq_pkg.sv
hdl/llpq_cell.sv
hdl/llpq_row.sv
hdl/least_loaded_priority_queue_dispatch_top.sv
hdl/llpq_checker.sv
bench/testbench.sv
